[rtl/core/tct_pkg.sv]
`default_nettype none

package tct_pkg;

    localparam logic [3:0] ST_CLOSE       = 4'd0;
    localparam logic [3:0] ST_LISTEN      = 4'd1;
    localparam logic [3:0] ST_SYN_SENT    = 4'd2;
    localparam logic [3:0] ST_SYN_RECV    = 4'd3;
    localparam logic [3:0] ST_ESTABLISHED = 4'd4;
    localparam logic [3:0] ST_FIN_WAIT1   = 4'd5;
    localparam logic [3:0] ST_FIN_WAIT2   = 4'd6;
    localparam logic [3:0] ST_CLOSE_WAIT  = 4'd7;
    localparam logic [3:0] ST_LAST_ACK    = 4'd8;
    localparam logic [3:0] ST_TIME_WAIT   = 4'd9;

    localparam logic [2:0] ACT_IGNORED   = 3'd0;
    localparam logic [2:0] ACT_OOO       = 3'd1;
    localparam logic [2:0] ACT_PROCESSED = 3'd2;
    localparam logic [2:0] ACT_RESET     = 3'd3;
    localparam logic [2:0] ACT_FINISHED  = 3'd4;

    typedef struct packed {
        logic        direction;
        logic        syn_flag;
        logic        ack_flag;
        logic        fin_flag;
        logic        rst_flag;
        logic [31:0] seg_seq;
        logic [31:0] ack_num;
        logic [15:0] payload_len;
    } tct_item_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [3:0]  state_a;
        logic [3:0]  state_b;
        logic [15:0] deliver_offset;
        logic [15:0] deliver_len;
    } tct_result_t;

    typedef struct packed {
        tct_item_t   item;
        logic [31:0] seq_plus1;
        logic [31:0] seg_end;
    } tct_work_t;

endpackage

`default_nettype wire

[rtl/core/tct_fifo.sv]
`default_nettype none

module tct_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    output logic                  full,
    input  wire logic [WIDTH-1:0] din,
    input  wire logic             pop,
    output logic                  empty,
    output logic      [WIDTH-1:0] dout
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

`default_nettype wire

[rtl/core/tct_front.sv]
`default_nettype none

module tct_front
    import tct_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    output logic           full,
    input  wire tct_item_t item,
    output logic           work_valid,
    input  wire logic      work_ready,
    output tct_work_t      work
);

    logic      valid_reg, valid_next;
    tct_work_t work_reg, work_next;
    logic      accept;

    assign full       = valid_reg && !work_ready;
    assign accept     = push && !full;
    assign work_valid = valid_reg;
    assign work       = work_reg;

    always_comb
    begin
        valid_next          = accept || (valid_reg && !work_ready);
        work_next.item      = item;
        work_next.seq_plus1 = item.seg_seq + 32'd1;
        work_next.seg_end   = item.seg_seq + {16'd0, item.payload_len};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            work_reg <= work_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/tct_back.sv]
`default_nettype none

module tct_back
    import tct_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      work_valid,
    output logic           work_pop,
    input  wire tct_work_t work,
    output logic           res_push,
    input  wire logic      res_full,
    output tct_result_t    res
);

    logic        active_reg, active_next;
    logic [3:0]  sa_reg, sa_next;
    logic [3:0]  sb_reg, sb_next;
    logic [31:0] na_reg, na_next;
    logic [31:0] nb_reg, nb_next;

    function automatic logic [7:0] tct_transition(
        input logic [3:0]  src_in,
        input logic [3:0]  dst_in,
        input logic [31:0] dst_seq,
        input logic        syn,
        input logic        ack,
        input logic        fin,
        input logic [31:0] ackn
    );
        logic [3:0] src;
        logic [3:0] dst;
        src = src_in;
        dst = dst_in;
        unique case (src_in)
            ST_CLOSE:
            begin
                if (syn && dst == ST_LISTEN)
                begin
                    src = ST_SYN_SENT;
                    dst = ST_SYN_RECV;
                end
            end
            ST_SYN_RECV:
            begin
                if (syn && ack && dst == ST_SYN_SENT && ackn == dst_seq)
                begin
                    dst = ST_ESTABLISHED;
                end
            end
            ST_ESTABLISHED:
            begin
                if (dst == ST_SYN_RECV && ack)
                begin
                    dst = ST_ESTABLISHED;
                end
                else if (dst == ST_ESTABLISHED && fin)
                begin
                    src = ST_FIN_WAIT1;
                    dst = ST_CLOSE_WAIT;
                end
            end
            ST_CLOSE_WAIT:
            begin
                if (dst == ST_FIN_WAIT1 && ackn == dst_seq)
                begin
                    dst = ST_FIN_WAIT2;
                end
                if ((dst == ST_FIN_WAIT2 || dst == ST_FIN_WAIT1) && fin)
                begin
                    src = ST_LAST_ACK;
                    dst = ST_TIME_WAIT;
                end
            end
            ST_TIME_WAIT:
            begin
                if (dst == ST_TIME_WAIT && ackn == dst_seq)
                begin
                    dst = ST_CLOSE;
                end
            end
            default:
            begin
            end
        endcase
        return {src, dst};
    endfunction

    logic        fire;
    logic        fresh;
    logic        ignored;
    logic        dir;
    logic [3:0]  base_sa, base_sb;
    logic [31:0] base_na, base_nb;
    logic [3:0]  src, dst, src_t, dst_t;
    logic [31:0] s_seq, d_seq, s_seq_new;
    logic [31:0] off;
    logic        off_lt;
    logic        in_span;
    logic        ooo;
    logic        deliver;
    logic        finish;
    logic [2:0]  action;
    logic [15:0] d_off, d_len;
    logic [3:0]  new_sa, new_sb;

    assign fire     = work_valid && !res_full;
    assign work_pop = fire;
    assign res_push = fire;

    always_comb
    begin
        fresh   = !active_reg && work.item.syn_flag;
        ignored = !active_reg && !work.item.syn_flag;
        base_sa = fresh ? ST_CLOSE : sa_reg;
        base_sb = fresh ? ST_LISTEN : sb_reg;
        base_na = fresh ? 32'd0 : na_reg;
        base_nb = fresh ? 32'd0 : nb_reg;
        dir     = fresh ? 1'b0 : work.item.direction;

        src   = dir ? base_sb : base_sa;
        dst   = dir ? base_sa : base_sb;
        s_seq = dir ? base_nb : base_na;
        d_seq = dir ? base_na : base_nb;

        off     = s_seq - work.item.seg_seq;
        off_lt  = (off[31:16] == 16'd0) && (off[15:0] < work.item.payload_len);
        in_span = off_lt || (off == 32'd0 && work.item.payload_len == 16'd0);
        ooo     = !ignored && !work.item.syn_flag && !in_span;

        {src_t, dst_t} = tct_transition(src, dst, d_seq, work.item.syn_flag,
                                        work.item.ack_flag, work.item.fin_flag,
                                        work.item.ack_num);

        deliver   = 1'b0;
        finish    = 1'b0;
        s_seq_new = s_seq;
        action    = ACT_PROCESSED;
        if (work.item.rst_flag)
        begin
            action = ACT_RESET;
            finish = 1'b1;
        end
        else
        begin
            unique case (src_t)
                ST_SYN_SENT, ST_SYN_RECV:
                begin
                    s_seq_new = work.seq_plus1;
                end
                ST_FIN_WAIT1, ST_CLOSE_WAIT, ST_LAST_ACK, ST_ESTABLISHED:
                begin
                    deliver   = off_lt && (work.item.payload_len != 16'd0);
                    s_seq_new = (deliver ? work.seg_end : s_seq)
                              + {31'd0, work.item.fin_flag};
                end
                ST_TIME_WAIT:
                begin
                    action = ACT_FINISHED;
                    finish = 1'b1;
                end
                default:
                begin
                end
            endcase
        end

        new_sa = dir ? dst_t : src_t;
        new_sb = dir ? src_t : dst_t;
        d_off  = deliver ? off[15:0] : 16'd0;
        d_len  = deliver ? (work.item.payload_len - off[15:0]) : 16'd0;

        active_next = active_reg;
        sa_next     = sa_reg;
        sb_next     = sb_reg;
        na_next     = na_reg;
        nb_next     = nb_reg;

        res.deliver_offset = 16'd0;
        res.deliver_len    = 16'd0;
        res.state_a        = sa_reg;
        res.state_b        = sb_reg;
        priority if (ignored)
        begin
            res.action = ACT_IGNORED;
        end
        else if (ooo)
        begin
            res.action = ACT_OOO;
        end
        else
        begin
            res.action         = action;
            res.state_a        = new_sa;
            res.state_b        = new_sb;
            res.deliver_offset = d_off;
            res.deliver_len    = d_len;
            if (fire)
            begin
                if (finish)
                begin
                    active_next = 1'b0;
                    sa_next     = ST_CLOSE;
                    sb_next     = ST_LISTEN;
                    na_next     = 32'd0;
                    nb_next     = 32'd0;
                end
                else
                begin
                    active_next = 1'b1;
                    sa_next     = new_sa;
                    sb_next     = new_sb;
                    na_next     = dir ? base_na : s_seq_new;
                    nb_next     = dir ? s_seq_new : base_nb;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            sa_reg     <= ST_CLOSE;
            sb_reg     <= ST_LISTEN;
            na_reg     <= 32'd0;
            nb_reg     <= 32'd0;
        end
        else
        begin
            active_reg <= active_next;
            sa_reg     <= sa_next;
            sb_reg     <= sb_next;
            na_reg     <= na_next;
            nb_reg     <= nb_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/tcp_connection_tracker.sv]
// Passive tracker for one TCP connection, fed with parsed segment headers.
// Input channel: a header transfer happens when push is high and full is low.
// Result channel: the oldest result sits on result while empty is low; a
// transfer happens when pop is high and empty is low. Every header gives
// exactly one result, in order.
// Throughput: one header per cycle, sustained, while the result side pops.
// Path: an accepted header is held in the front register, then in the work
// queue; the back end updates the session from it and writes the result
// into the result queue, from which it shows on the result port.
// The rate is set by the back end, which updates the session state for one
// header per cycle; the work queue lets the front keep taking headers while
// the back end stalls, and the result queue holds finished results.
// When the receiver stops popping, the result queue fills, the back end
// holds, then the work queue and front register fill and full rises.
// Reset clears all queues and returns the session to idle (side A CLOSE,
// side B LISTEN, sequence numbers zero); no results are pending after it.
`default_nettype none

module tcp_connection_tracker
    import tct_pkg::*;
#(
    parameter int QUEUE_DEPTH  = 2,
    parameter int RESULT_DEPTH = 2
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire tct_item_t   item,
    output logic             empty,
    input  wire logic        pop,
    output tct_result_t      result
);

    localparam int WORK_W   = $bits(tct_work_t);
    localparam int RESULT_W = $bits(tct_result_t);

    logic        front_valid;
    logic        work_full;
    tct_work_t   front_work;
    logic        work_empty;
    logic        work_pop;
    tct_work_t   back_work;
    logic        res_push;
    logic        res_full;
    tct_result_t back_res;

    tct_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .item       (item),
        .work_valid (front_valid),
        .work_ready (!work_full),
        .work       (front_work)
    );

    tct_fifo #(
        .WIDTH (WORK_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_work_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (front_valid),
        .full  (work_full),
        .din   (front_work),
        .pop   (work_pop),
        .empty (work_empty),
        .dout  (back_work)
    );

    tct_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .work_valid (!work_empty),
        .work_pop   (work_pop),
        .work       (back_work),
        .res_push   (res_push),
        .res_full   (res_full),
        .res        (back_res)
    );

    tct_fifo #(
        .WIDTH (RESULT_W),
        .DEPTH (RESULT_DEPTH)
    ) u_result_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .full  (res_full),
        .din   (back_res),
        .pop   (pop),
        .empty (empty),
        .dout  (result)
    );

endmodule

`default_nettype wire

[tb/tct_report_checker.sv]
module tct_report_checker
    import tct_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  tct_item_t   item,
    input  logic        empty,
    input  logic        pop,
    input  tct_result_t result,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic        session_on;
    logic [3:0]  st_a;
    logic [3:0]  st_b;
    logic [31:0] nxt_a;
    logic [31:0] nxt_b;

    tct_result_t pending_reports[$];

    function automatic void clear_session();
        session_on = 1'b0;
        st_a       = ST_CLOSE;
        st_b       = ST_LISTEN;
        nxt_a      = '0;
        nxt_b      = '0;
    endfunction

    function automatic bit covers_seq(logic [31:0] lo, logic [31:0] pos, logic [31:0] hi);
        if (lo == pos && pos == hi)
            return 1'b1;
        if (lo <= hi)
            return lo <= pos && pos < hi;
        return !(hi <= pos && pos < lo);
    endfunction

    function automatic tct_result_t track_segment(tct_item_t seg);
        logic        dir;
        logic [3:0]  src;
        logic [3:0]  dst;
        logic [31:0] src_seq;
        logic [31:0] dst_seq;
        logic [31:0] span_end;
        logic [31:0] off;
        logic [2:0]  act;
        logic [15:0] d_off;
        logic [15:0] d_len;
        logic        ends;
        tct_result_t r;
        act   = ACT_PROCESSED;
        d_off = '0;
        d_len = '0;
        ends  = 1'b0;
        dir   = seg.direction;
        if (!session_on)
        begin
            if (seg.syn_flag)
            begin
                clear_session();
                session_on = 1'b1;
                dir        = 1'b0;
            end
            else
            begin
                act = ACT_IGNORED;
            end
        end
        src      = dir ? st_b : st_a;
        dst      = dir ? st_a : st_b;
        src_seq  = dir ? nxt_b : nxt_a;
        dst_seq  = dir ? nxt_a : nxt_b;
        span_end = seg.seg_seq + {16'd0, seg.payload_len};
        if (act != ACT_IGNORED && !seg.syn_flag && !covers_seq(seg.seg_seq, src_seq, span_end))
            act = ACT_OOO;
        if (act == ACT_PROCESSED)
        begin
            case (src)
                ST_CLOSE:
                begin
                    if (seg.syn_flag && dst == ST_LISTEN)
                    begin
                        src = ST_SYN_SENT;
                        dst = ST_SYN_RECV;
                    end
                end
                ST_SYN_RECV:
                begin
                    if (seg.syn_flag && seg.ack_flag && dst == ST_SYN_SENT
                        && seg.ack_num == dst_seq)
                        dst = ST_ESTABLISHED;
                end
                ST_ESTABLISHED:
                begin
                    if (dst == ST_SYN_RECV && seg.ack_flag)
                    begin
                        dst = ST_ESTABLISHED;
                    end
                    else if (dst == ST_ESTABLISHED && seg.fin_flag)
                    begin
                        src = ST_FIN_WAIT1;
                        dst = ST_CLOSE_WAIT;
                    end
                end
                ST_CLOSE_WAIT:
                begin
                    if (dst == ST_FIN_WAIT1 && seg.ack_num == dst_seq)
                        dst = ST_FIN_WAIT2;
                    if ((dst == ST_FIN_WAIT2 || dst == ST_FIN_WAIT1) && seg.fin_flag)
                    begin
                        src = ST_LAST_ACK;
                        dst = ST_TIME_WAIT;
                    end
                end
                ST_TIME_WAIT:
                begin
                    if (dst == ST_TIME_WAIT && seg.ack_num == dst_seq)
                        dst = ST_CLOSE;
                end
                default: ;
            endcase
            if (seg.rst_flag)
            begin
                act  = ACT_RESET;
                ends = 1'b1;
            end
            else
            begin
                case (src)
                    ST_SYN_SENT, ST_SYN_RECV:
                    begin
                        src_seq = seg.seg_seq + 32'd1;
                    end
                    ST_FIN_WAIT1, ST_CLOSE_WAIT, ST_LAST_ACK, ST_ESTABLISHED:
                    begin
                        off = src_seq - seg.seg_seq;
                        if (seg.payload_len != 0 && off < {16'd0, seg.payload_len})
                        begin
                            d_off   = off[15:0];
                            d_len   = seg.payload_len - off[15:0];
                            src_seq = src_seq + {16'd0, d_len};
                        end
                        if (seg.fin_flag)
                            src_seq = src_seq + 32'd1;
                    end
                    ST_TIME_WAIT:
                    begin
                        act  = ACT_FINISHED;
                        ends = 1'b1;
                    end
                    default: ;
                endcase
            end
            if (dir)
            begin
                st_b  = src;
                st_a  = dst;
                nxt_b = src_seq;
            end
            else
            begin
                st_a  = src;
                st_b  = dst;
                nxt_a = src_seq;
            end
        end
        r.action         = act;
        r.state_a        = st_a;
        r.state_b        = st_b;
        r.deliver_offset = d_off;
        r.deliver_len    = d_len;
        if (ends)
            clear_session();
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        tct_result_t want;
        if (!rst_n)
        begin
            clear_session();
            pending_reports.delete();
            fail_count = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (pending_reports.size() == 0)
                begin
                    $error("result transfer with no report outstanding");
                    fail_count++;
                end
                else
                begin
                    want = pending_reports.pop_front();
                    check_field("action", 32'(want.action), 32'(result.action));
                    check_field("state_a", 32'(want.state_a), 32'(result.state_a));
                    check_field("state_b", 32'(want.state_b), 32'(result.state_b));
                    check_field("deliver_offset", 32'(want.deliver_offset),
                                32'(result.deliver_offset));
                    check_field("deliver_len", 32'(want.deliver_len),
                                32'(result.deliver_len));
                end
            end
            if (push && !full)
                pending_reports.push_back(track_segment(item));
        end
        pending = pending_reports.size();
    end

endmodule

[tb/tb_top.sv]
module tb_top
    import tct_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        push  = 1'b0;
    logic        full;
    tct_item_t   seg   = '0;
    logic        empty;
    logic        pop   = 1'b0;
    tct_result_t result;

    int          check_errors;
    int          pending;
    int          sent_items = 0;
    int          gap_pct    = 20;
    int          stall_pct  = 20;
    logic [31:0] next_a     = '0;
    logic [31:0] next_b     = '0;

    tcp_connection_tracker dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (seg),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    tct_report_checker report_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .item       (seg),
        .empty      (empty),
        .pop        (pop),
        .result     (result),
        .fail_count (check_errors),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        #5ms;
        $display("TB_ERROR");
        $finish;
    end

    function automatic tct_item_t make_seg(logic dir, logic syn, logic ack, logic fin, logic rst,
                                           logic [31:0] sq, logic [31:0] ackn,
                                           logic [15:0] plen);
        tct_item_t s;
        s.direction   = dir;
        s.syn_flag    = syn;
        s.ack_flag    = ack;
        s.fin_flag    = fin;
        s.rst_flag    = rst;
        s.seg_seq     = sq;
        s.ack_num     = ackn;
        s.payload_len = plen;
        return s;
    endfunction

    function automatic logic [15:0] pick_len();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 3)
            return 16'd0;
        if (roll < 9)
            return 16'($urandom_range(1, 64));
        return 16'($urandom_range(1, 65535));
    endfunction

    function automatic tct_item_t noise_seg();
        return make_seg(1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0,
                        1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                        $urandom_range(0, 3) == 0, $urandom, $urandom, pick_len());
    endfunction

    function automatic logic [31:0] next_of(logic dir);
        return dir ? next_b : next_a;
    endfunction

    task automatic send_seg(input tct_item_t s);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        push <= 1'b1;
        seg  <= s;
        do
            @(posedge clk);
        while (full);
        sent_items++;
    endtask

    // overlap the expected sequence now and then, as a retransmit would
    task automatic send_data(input logic dir, input logic fin, input logic ack);
        logic [31:0] nx;
        logic [31:0] sq;
        logic [31:0] ackn;
        logic [15:0] p;
        logic [15:0] back;
        nx   = next_of(dir);
        p    = pick_len();
        back = (p != 0 && $urandom_range(0, 3) == 0) ? 16'($urandom_range(0, p - 1)) : 16'd0;
        sq   = nx - {16'd0, back};
        ackn = ($urandom_range(0, 15) == 0) ? $urandom : next_of(!dir);
        send_seg(make_seg(dir, 1'b0, ack, fin, 1'b0, sq, ackn, p));
        if (p != 0)
            nx = sq + {16'd0, p};
        if (fin)
            nx = nx + 32'd1;
        if (dir)
            next_b = nx;
        else
            next_a = nx;
    endtask

    task automatic play_session();
        logic [31:0] isn_a;
        logic [31:0] isn_b;
        logic        dir;
        logic        closer;
        int          n_data;
        if (sent_items >= 1300)
        begin
            gap_pct   = 0;
            stall_pct = 0;
        end
        else
        begin
            gap_pct   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
            stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
        end
        isn_a = $urandom;
        isn_b = $urandom;
        if ($urandom_range(0, 7) == 0)
            isn_a = 32'hFFFF_FFF0 | $urandom_range(0, 15);
        if ($urandom_range(0, 7) == 0)
            isn_b = 32'hFFFF_FFF0 | $urandom_range(0, 15);
        send_seg(make_seg(1'($urandom_range(0, 1)), 1'b1, 1'($urandom_range(0, 1)), 1'b0, 1'b0,
                          isn_a, $urandom, 16'd0));
        next_a = isn_a + 32'd1;
        send_seg(make_seg(1'b1, 1'b1, 1'b1, 1'b0, 1'b0, isn_b,
                          ($urandom_range(0, 15) == 0) ? $urandom : next_a, 16'd0));
        next_b = isn_b + 32'd1;
        send_data(1'b0, 1'b0, 1'b1);
        n_data = $urandom_range(0, 12);
        for (int k = 0; k < n_data; k++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_seg(noise_seg());
            end
            else
            begin
                dir = 1'($urandom_range(0, 1));
                send_data(dir, 1'b0, $urandom_range(0, 7) != 0);
            end
        end
        if ($urandom_range(0, 9) == 0)
        begin
            dir = 1'($urandom_range(0, 1));
            send_seg(make_seg(dir, 1'b0, 1'b1, 1'b0, 1'b1, next_of(dir), $urandom, 16'd0));
            return;
        end
        closer = 1'($urandom_range(0, 1));
        send_data(closer, 1'b1, 1'b1);
        if ($urandom_range(0, 2) != 0)
            send_data(!closer, 1'b0, 1'b1);
        send_data(!closer, 1'b1, 1'b1);
        send_seg(make_seg(closer, 1'b0, 1'b1, 1'b0, 1'b0, next_of(closer),
                          next_of(!closer), 16'd0));
    endtask

    // receiver: random stalls, plus two long holds to back the block up
    initial
    begin : drain
        int popped;
        int choke_at;
        int holds_left;
        int hold;
        popped     = 0;
        choke_at   = 300;
        holds_left = 2;
        wait (rst_n === 1'b1);
        forever
        begin
            if (holds_left > 0 && popped >= choke_at)
            begin
                holds_left--;
                choke_at = choke_at + 500;
                pop <= 1'b0;
                hold = 60;
            end
            else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
            begin
                pop <= 1'b0;
                hold = $urandom_range(1, 18);
            end
            else
            begin
                pop <= 1'b1;
                hold = 1;
            end
            repeat (hold)
            begin
                @(posedge clk);
                if (pop && !empty)
                    popped++;
            end
        end
    end

    initial
    begin : stimulus
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // no session yet
        send_seg(make_seg(1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF));
        send_seg(make_seg(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 32'h0, 32'h0, 16'h0));
        // open from direction 1, sequence wraps to zero
        send_seg(make_seg(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 32'hFFFF_FFFF, 32'h0, 16'h0));
        send_seg(make_seg(1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 32'h7FFF_FFFF, 32'h0, 16'h0));
        send_seg(make_seg(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 32'h0, 32'h8000_0000, 16'h0));
        // full payload across the wrap with partial overlap
        send_seg(make_seg(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 32'hFFFF_FF9C, 32'h8000_0000, 16'hFFFF));
        send_seg(make_seg(1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 32'h1234_5678, 32'h0, 16'h0));
        send_seg(make_seg(1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 32'h8000_0000, 32'h0000_FF9B, 16'h1));
        // SYN in a data state: bytes past the expected sequence, then partial overlap
        send_seg(make_seg(1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 32'h0000_FFA0, 32'h0, 16'h3));
        send_seg(make_seg(1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 32'h7FFF_FFFF, 32'h0, 16'h5));
        // orderly close from side A
        send_seg(make_seg(1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 32'h0000_FF9B, 32'h8000_0004, 16'd10));
        send_seg(make_seg(1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 32'h8000_0004, 32'h0000_FFA6, 16'h0));
        send_seg(make_seg(1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 32'h8000_0004, 32'h0000_FFA6, 16'h0));
        send_seg(make_seg(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 32'h0000_FFA6, 32'h8000_0005, 16'h0));
        // bad ack on the SYN-ACK, then reset
        send_seg(make_seg(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 32'h0, 32'h0, 16'h0));
        send_seg(make_seg(1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 32'h10, 32'h5, 16'h0));
        send_seg(make_seg(1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 32'h11, 32'h0, 16'h0));
        send_seg(make_seg(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 32'h1, 32'h11, 16'h4));

        while (sent_items < 1450)
            play_session();
        push <= 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (8) @(posedge clk);
        if (check_errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
